// ----- src/rlce_pkg.sv -----
// Package for the RGB LED chain frame encoder.
// Holds sizes, command codes and the word types that the modules share.
// No dependencies.
package rlce_pkg;

  localparam int MAX_LEDS     = 128;
  localparam int IDX_W        = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W        = $clog2(MAX_LEDS + 1);
  localparam int COLOUR_W     = 24;
  localparam int CHUNK_W      = 64;
  localparam int CHUNK_CNT_W  = 6;
  localparam int LEAD_W       = 6;
  localparam int LEAD_MIN     = 50;
  localparam int BITS_PER_LED = 25;
  localparam int POS_W        = 5;

  localparam logic [1:0] CMD_SET_ONE = 2'd0;
  localparam logic [1:0] CMD_SET_ALL = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_word_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [3:0]         byte_count;
    logic               last;
  } result_word_t;

  typedef struct packed {
    logic valid;
    logic value;
    logic fin;
  } stream_bit_t;

endpackage

// ----- src/rlce_store.sv -----
// Colour store: one write port, one registered read port.
// Valid bits read back unwritten entries as zero after reset.
// Depends on rlce_pkg.
module rlce_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [rlce_pkg::IDX_W-1:0]          waddr,
  input  logic [rlce_pkg::COLOUR_W-1:0]       wdata,
  input  logic                                re,
  input  logic [rlce_pkg::IDX_W-1:0]          raddr,
  output logic [rlce_pkg::COLOUR_W-1:0]       rdata
);

  logic [rlce_pkg::COLOUR_W-1:0] mem [rlce_pkg::MAX_LEDS];
  logic [rlce_pkg::MAX_LEDS-1:0] valid;
  logic [rlce_pkg::COLOUR_W-1:0] rd_q;
  logic                          rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ----- src/rlce_bitgen.sv -----
// Stream bit generator: lead zeros, then per LED a start bit and 24 colour bits.
// Fetches each colour from the store during its start bit. Depends on rlce_pkg.
module rlce_bitgen (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [rlce_pkg::CNT_W-1:0]    n,
  input  logic [rlce_pkg::LEAD_W-1:0]   lead,
  input  logic [rlce_pkg::COLOUR_W-1:0] rdata,
  output logic                          re,
  output logic [rlce_pkg::IDX_W-1:0]    raddr,
  output rlce_pkg::stream_bit_t         sbit,
  output logic                          active
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEAD = 2'd1;
  localparam logic [1:0] ST_LED  = 2'd2;
  localparam logic [rlce_pkg::POS_W-1:0] POS_LAST =
    rlce_pkg::POS_W'(rlce_pkg::BITS_PER_LED - 1);

  logic [1:0]                     state;
  logic [rlce_pkg::LEAD_W-1:0]    lead_cnt;
  logic [rlce_pkg::CNT_W-1:0]     led;
  logic [rlce_pkg::CNT_W-1:0]     led_next;
  logic [rlce_pkg::CNT_W-1:0]     n_q;
  logic [rlce_pkg::POS_W-1:0]     pos;
  logic [rlce_pkg::COLOUR_W-1:0]  colour_sr;

  assign led_next = rlce_pkg::CNT_W'(led + 1'b1);
  assign active   = (state != ST_IDLE);
  assign re       = (state == ST_LED) && (pos == '0);
  assign raddr    = rlce_pkg::IDX_W'(led);

  always_comb begin
    sbit.valid = 1'b0;
    sbit.value = 1'b0;
    sbit.fin   = 1'b0;
    case (state)
      ST_LEAD: begin
        sbit.valid = 1'b1;
        sbit.fin   = (lead_cnt == '0) && (n_q == '0);
      end
      ST_LED: begin
        sbit.valid = 1'b1;
        if (pos == '0) begin
          sbit.value = 1'b1;
        end else if (pos == rlce_pkg::POS_W'(1)) begin
          sbit.value = rdata[rlce_pkg::COLOUR_W-1];
        end else begin
          sbit.value = colour_sr[rlce_pkg::COLOUR_W-1];
        end
        sbit.fin = (pos == POS_LAST) && (led_next == n_q);
      end
      default: begin
        sbit.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go) begin
            state <= ST_LEAD;
          end
        end
        ST_LEAD: begin
          if (lead_cnt == '0) begin
            state <= (n_q == '0) ? ST_IDLE : ST_LED;
          end
        end
        ST_LED: begin
          if (sbit.fin) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      lead_cnt <= rlce_pkg::LEAD_W'(lead - 1'b1);
      led      <= '0;
      pos      <= '0;
      n_q      <= n;
    end else if (state == ST_LEAD) begin
      lead_cnt <= rlce_pkg::LEAD_W'(lead_cnt - 1'b1);
    end else begin
      if (pos == rlce_pkg::POS_W'(1)) begin
        colour_sr <= {rdata[rlce_pkg::COLOUR_W-2:0], 1'b0};
      end else begin
        colour_sr <= {colour_sr[rlce_pkg::COLOUR_W-2:0], 1'b0};
      end
      if (pos == POS_LAST) begin
        pos <= '0;
        led <= led_next;
      end else begin
        pos <= rlce_pkg::POS_W'(pos + 1'b1);
      end
    end
  end

endmodule

// ----- src/rlce_packer.sv -----
// Chunk packer: shifts stream bits into a 64-bit word and emits full chunks.
// Pads the final partial chunk with zeros. Depends on rlce_pkg.
module rlce_packer (
  input  logic                   clk,
  input  logic                   rst,
  input  rlce_pkg::stream_bit_t  sbit,
  output rlce_pkg::result_word_t result,
  output logic                   strobe,
  output logic                   padding
);

  logic [rlce_pkg::CHUNK_W-1:0]     sr;
  logic [rlce_pkg::CHUNK_W-1:0]     sr_next;
  logic [rlce_pkg::CHUNK_CNT_W-1:0] cnt;
  logic [3:0]                       pad_bytes;
  logic                             shift;
  logic                             full;

  assign shift   = sbit.valid || padding;
  assign full    = (cnt == {rlce_pkg::CHUNK_CNT_W{1'b1}});
  assign sr_next = {sr[rlce_pkg::CHUNK_W-2:0], sbit.valid & sbit.value};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      padding <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (shift) begin
        if (full) begin
          strobe  <= 1'b1;
          cnt     <= '0;
          padding <= 1'b0;
        end else begin
          cnt <= rlce_pkg::CHUNK_CNT_W'(cnt + 1'b1);
          if (sbit.valid && sbit.fin) begin
            padding <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sr <= sr_next;
      if (sbit.valid && sbit.fin) begin
        pad_bytes <= 4'(({1'b0, cnt} + 7'd1) >> 3);
      end
      if (full) begin
        result.chunk      <= sr_next;
        result.byte_count <= padding ? pad_bytes : 4'd8;
        result.last       <= padding | (sbit.valid & sbit.fin);
      end
    end
  end

endmodule

// ----- src/rgb_led_chain_frame_encoder.sv -----
// RGB LED chain frame encoder: top level.
// Command decode, set-all sweep, store, bit generator and chunk packer.
// Depends on rlce_pkg, rlce_store, rlce_bitgen, rlce_packer.
//
// Usage: a command word is taken at a clock edge with start high and busy low.
// Set-one writes one colour at that edge; busy stays low. Set-all sweeps the
// store one entry per cycle over led_count entries (capped at MAX_LEDS), with
// busy high. Refresh generates the stream one bit per cycle: 50 to 57 lead
// zeros, then 25 bits per LED, and the last partial chunk is padded out bit by
// bit, with busy high until the final chunk is emitted. Each chunk appears on
// result for one cycle with strobe high; last marks the final chunk. The
// receiver cannot stall. led_count is written through cfg_we/cfg_wdata; the
// user must write it only while idle, which the block itself does not enforce.
// Reset clears the colour store to zero and sets led_count to 1.
module rgb_led_chain_frame_encoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rlce_pkg::cmd_word_t    cmd_word,
  output logic                   busy,
  output rlce_pkg::result_word_t result,
  output logic                   strobe,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata
);

  logic [7:0]                     led_count;
  logic [rlce_pkg::CNT_W-1:0]     n;
  logic [2:0]                     pad;
  logic [rlce_pkg::LEAD_W-1:0]    lead;
  logic                           accept;
  logic                           sweep_active;
  logic [rlce_pkg::CNT_W-1:0]     sweep_idx;
  logic [rlce_pkg::CNT_W-1:0]     sweep_idx_next;
  logic [rlce_pkg::COLOUR_W-1:0]  colour;
  logic [rlce_pkg::COLOUR_W-1:0]  colour_q;
  logic                           we;
  logic [rlce_pkg::IDX_W-1:0]     waddr;
  logic [rlce_pkg::COLOUR_W-1:0]  wdata;
  logic                           re;
  logic [rlce_pkg::IDX_W-1:0]     raddr;
  logic [rlce_pkg::COLOUR_W-1:0]  rdata;
  rlce_pkg::stream_bit_t          sbit;
  logic                           bg_active;
  logic                           padding;

  always_comb begin
    if (int'(led_count) > rlce_pkg::MAX_LEDS) begin
      n = rlce_pkg::CNT_W'(rlce_pkg::MAX_LEDS);
    end else begin
      n = rlce_pkg::CNT_W'(led_count);
    end
  end

  assign pad    = 3'(3'd6 - 3'(n));
  assign lead   = rlce_pkg::LEAD_W'(rlce_pkg::LEAD_MIN) + rlce_pkg::LEAD_W'(pad);
  assign busy   = bg_active | padding | sweep_active;
  assign accept = start && !busy;
  assign colour = {cmd_word.blue, cmd_word.red, cmd_word.green};
  assign sweep_idx_next = rlce_pkg::CNT_W'(sweep_idx + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= 8'd1;
    end else if (cfg_we) begin
      led_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b0;
      sweep_idx    <= '0;
    end else if (sweep_active) begin
      sweep_idx <= sweep_idx_next;
      if (sweep_idx_next == n) begin
        sweep_active <= 1'b0;
      end
    end else if (accept && cmd_word.cmd == rlce_pkg::CMD_SET_ALL && n != '0) begin
      sweep_active <= 1'b1;
      sweep_idx    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      colour_q <= colour;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = rlce_pkg::IDX_W'(sweep_idx);
    wdata = colour_q;
    if (sweep_active) begin
      we = 1'b1;
    end else if (accept && cmd_word.cmd == rlce_pkg::CMD_SET_ONE &&
                 int'(cmd_word.led_index) < int'(n)) begin
      we    = 1'b1;
      waddr = rlce_pkg::IDX_W'(cmd_word.led_index);
      wdata = colour;
    end
  end

  rlce_store u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rlce_bitgen u_bitgen (
    .clk    (clk),
    .rst    (rst),
    .go     (accept && cmd_word.cmd == rlce_pkg::CMD_REFRESH),
    .n      (n),
    .lead   (lead),
    .rdata  (rdata),
    .re     (re),
    .raddr  (raddr),
    .sbit   (sbit),
    .active (bg_active)
  );

  rlce_packer u_packer (
    .clk     (clk),
    .rst     (rst),
    .sbit    (sbit),
    .result  (result),
    .strobe  (strobe),
    .padding (padding)
  );

endmodule

// ----- src/rlce_checker.sv -----
// Port-level checker for the RGB LED chain frame encoder.
// Bound to the top level below. Depends on rlce_pkg.
module rlce_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input rlce_pkg::cmd_word_t    cmd_word,
  input logic                   busy,
  input rlce_pkg::result_word_t result,
  input logic                   strobe
);

  logic refresh_acc;
  assign refresh_acc = start && !busy && cmd_word.cmd == rlce_pkg::CMD_REFRESH;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.byte_count != 4'd0 && result.byte_count <= 4'd8))
    else $error("byte_count out of range");

  a_full_mid: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.byte_count == 4'd8)
    else $error("non-final chunk not full");

  a_refresh_busy: assert property (@(posedge clk) disable iff (rst)
    refresh_acc |=> busy)
    else $error("refresh did not raise busy");

  a_refresh_quiet: assert property (@(posedge clk) disable iff (rst)
    refresh_acc |=> !strobe)
    else $error("chunk right after refresh start");

endmodule

bind rgb_led_chain_frame_encoder rlce_checker u_rlce_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .cmd_word (cmd_word),
  .busy     (busy),
  .result   (result),
  .strobe   (strobe)
);

// ----- tb/tb_rgb_led_chain_frame_encoder.sv -----
// Testbench for rgb_led_chain_frame_encoder: drives commands of all kinds and led_count writes, and
// checks every emitted chunk against typed chunks or an in-bench frame encoder.
// Depends on rlce_pkg and the encoder RTL.
module tb_rgb_led_chain_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import rlce_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int IDLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 230;

  typedef struct packed {
    logic         is_cfg;
    logic [7:0]   cfg_val;
    cmd_word_t    word;
    logic [1:0]   n_typed;
    result_word_t typed0;
    result_word_t typed1;
  } dir_row_t;

  localparam result_word_t NO_CHUNK = '0;

  logic         clk;
  logic         rst;
  logic         start;
  cmd_word_t    cmd_word;
  logic         busy;
  result_word_t result;
  logic         strobe;
  logic         cfg_we;
  logic [7:0]   cfg_wdata;

  logic [23:0]  led_colours [MAX_LEDS];
  logic [7:0]   led_count_now;
  result_word_t chunks_due [$];
  result_word_t typed_hold [2];
  int           typed_n;
  int           mismatches;
  int           quiet_cycles;
  bit           no_gaps;

  dir_row_t dir_rows [25] = '{
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd2,
      '{64'h0000_0000_0000_0100, 4'd8, 1'b0}, '{64'h0, 4'd2, 1'b1}},
    '{1'b0, 8'd0, '{CMD_SET_ALL, 7'd0, 8'hff, 8'hff, 8'hff}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd2,
      '{64'h0000_0000_0000_01ff, 4'd8, 1'b0}, '{64'hffff_0000_0000_0000, 4'd2, 1'b1}},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd1, 8'h12, 8'h34, 8'h56}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd0, 8'h01, 8'h7f, 8'h80}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_UNUSED, 7'd127, 8'hff, 8'hff, 8'hff}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd127, 8'hff, 8'hff, 8'hff}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b1, 8'd0, '0, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd1,
      '{64'h0, 4'd7, 1'b1}, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ALL, 7'd0, 8'h55, 8'h55, 8'h55}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd0, 8'haa, 8'haa, 8'haa}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd1,
      '{64'h0, 4'd7, 1'b1}, NO_CHUNK},
    '{1'b1, 8'd128, '0, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ALL, 7'd0, 8'haa, 8'h55, 8'h0f}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd127, 8'h00, 8'hff, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b1, 8'd255, '0, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd127, 8'hff, 8'hff, 8'hff}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b1, 8'd2, '0, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_SET_ONE, 7'd1, 8'h80, 8'h01, 8'hfe}, 2'd0, NO_CHUNK, NO_CHUNK},
    '{1'b0, 8'd0, '{CMD_REFRESH, 7'd0, 8'h00, 8'h00, 8'h00}, 2'd0, NO_CHUNK, NO_CHUNK}
  };

  rgb_led_chain_frame_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_word  (cmd_word),
    .busy      (busy),
    .result    (result),
    .strobe    (strobe),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int active_leds(logic [7:0] count);
    return (count > MAX_LEDS) ? MAX_LEDS : int'(count);
  endfunction

  function automatic logic frame_bit(int pos, int lead, int n);
    int q;
    int led_no;
    int r;
    if (pos < lead) return 1'b0;
    q = pos - lead;
    led_no = q / BITS_PER_LED;
    r = q % BITS_PER_LED;
    if (r == 0) return 1'b1;
    if (led_no >= n) return 1'b0;
    return led_colours[led_no][24 - r];
  endfunction

  function automatic void encode_frame(int n);
    int lead;
    int total_bytes;
    int n_chunks;
    int nbytes;
    logic [63:0] val;
    lead = LEAD_MIN + ((8 - ((n * BITS_PER_LED + LEAD_MIN) % 8)) % 8);
    total_bytes = (lead + n * BITS_PER_LED) / 8;
    n_chunks = (total_bytes + 7) / 8;
    for (int c = 0; c < n_chunks; c++) begin
      nbytes = (total_bytes - c * 8 > 8) ? 8 : total_bytes - c * 8;
      val = '0;
      for (int b = 0; b < nbytes * 8; b++) val[63 - b] = frame_bit(c * 64 + b, lead, n);
      chunks_due.push_back(result_word_t'{val, 4'(nbytes), c == n_chunks - 1});
    end
  endfunction

  function automatic void apply_command(cmd_word_t w);
    int n;
    n = active_leds(led_count_now);
    case (w.cmd)
      CMD_SET_ONE: begin
        if (w.led_index < n) led_colours[w.led_index] = {w.blue, w.red, w.green};
      end
      CMD_SET_ALL: begin
        for (int i = 0; i < n; i++) led_colours[i] = {w.blue, w.red, w.green};
      end
      CMD_REFRESH: encode_frame(n);
      default: ;
    endcase
  endfunction

  function automatic void check_chunk(result_word_t got);
    result_word_t want;
    if (chunks_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected chunk %h bytes %0d last %0b", got.chunk, got.byte_count, got.last);
    end else begin
      want = chunks_due.pop_front();
      if (got.chunk !== want.chunk || got.byte_count !== want.byte_count ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("chunk mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                   want.chunk, want.byte_count, want.last,
                   got.chunk, got.byte_count, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) check_chunk(result);
      if (cfg_we) led_count_now = cfg_wdata;
      if (start && !busy) begin
        if (typed_n != 0) begin
          for (int i = 0; i < typed_n; i++) chunks_due.push_back(typed_hold[i]);
          typed_n = 0;
        end else begin
          apply_command(cmd_word);
        end
      end
      if (strobe || cfg_we || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(cmd_word_t w);
    cmd_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int cycles;
    cycles = no_gaps ? 0 : $urandom_range(0, 18);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // hold off until every due chunk has arrived
  task automatic drain_chunks();
    start <= 1'b0;
    do @(negedge clk); while (chunks_due.size() != 0);
  endtask

  task automatic write_led_count(logic [7:0] value);
    drain_chunks();
    while (busy) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] phase_plan [10] = '{8'd4, 8'd1, 8'd17, 8'd0, 8'd128,
                                    8'd9, 8'd3, 8'd200, 8'd25, 8'd6};
    cmd_word_t w;
    logic [7:0] count_val;
    int counted;
    int phase;
    int eff;
    int quota;
    int pick;
    rst = 1'b1;
    start = 1'b0;
    cmd_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    typed_n = 0;
    mismatches = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    led_count_now = 8'd1;
    foreach (led_colours[i]) led_colours[i] = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_led_count(dir_rows[i].cfg_val);
      end else begin
        typed_n = dir_rows[i].n_typed;
        typed_hold[0] = dir_rows[i].typed0;
        typed_hold[1] = dir_rows[i].typed1;
        send_word(dir_rows[i].word);
        sender_gap();
      end
    end

    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      count_val = (phase < 10) ? phase_plan[phase] : 8'($urandom_range(1, 20));
      write_led_count(count_val);
      eff = active_leds(count_val);
      quota = (eff > 40) ? 8 : 28;
      no_gaps = ($urandom_range(0, 3) == 0);
      while (quota > 0 && counted < RANDOM_ITEMS) begin
        pick = $urandom_range(0, 99);
        w.cmd = (pick < 45) ? CMD_SET_ONE : (pick < 58) ? CMD_SET_ALL :
                (pick < 93) ? CMD_REFRESH : CMD_UNUSED;
        if (eff > 0 && $urandom_range(0, 99) < 85) w.led_index = 7'($urandom_range(0, eff - 1));
        else w.led_index = 7'($urandom_range(0, 127));
        w.red = 8'($urandom);
        w.green = 8'($urandom);
        w.blue = 8'($urandom);
        counted++;
        quota--;
        if ($urandom_range(0, 19) == 0) drain_chunks();
        send_word(w);
        sender_gap();
      end
      phase++;
    end

    drain_chunks();
    repeat (IDLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && chunks_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- rgb_led_chain_frame_encoder.f -----
src/rlce_pkg.sv
src/rlce_store.sv
src/rlce_bitgen.sv
src/rlce_packer.sv
src/rgb_led_chain_frame_encoder.sv
src/rlce_checker.sv
tb/tb_rgb_led_chain_frame_encoder.sv
